### rtl/feistel_block_cipher_64_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 64-bit Feistel block cipher
// Shorthand for clocked implication properties, reset disables them.
// ----------------------------------------------------------------------------
`ifndef FEISTEL_BLOCK_CIPHER_64_MACROS_SVH
`define FEISTEL_BLOCK_CIPHER_64_MACROS_SVH

// Same-cycle implication.
`define FC64_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fc64 assertion failed");

// Next-cycle implication.
`define FC64_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fc64 assertion failed");

`endif

### rtl/fc64_pkg.sv
// ----------------------------------------------------------------------------
// fc64_pkg
// Types, register codes and the round function of the 64-bit Feistel cipher.
// ----------------------------------------------------------------------------
package fc64_pkg;

	localparam int MAX_ROUNDS_DEF = 16;
	// Wide enough for a round count of up to 32.
	localparam int RND_W = 6;
	localparam int KEY_WORDS = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_SIZE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROUNDS     = 3'd5;

	localparam logic [1:0] KEY_SIZE_16 = 2'd0;
	localparam logic [1:0] KEY_SIZE_24 = 2'd1;
	localparam logic [1:0] KEY_SIZE_32 = 2'd2;

	localparam logic FUNC_ENC = 1'b0;
	localparam logic FUNC_DEC = 1'b1;

	localparam logic [4:0] ROUNDS_RESET = 5'd6;
	localparam logic [7:0] GF_POLY = 8'h1b;

	typedef struct packed {
		logic        func;
		logic [63:0] block;
	} fc64_word_t;

	typedef struct packed {
		logic [KEY_WORDS-1:0][15:0] key_words;
		logic [1:0]                 size_sel;
		logic [RND_W-1:0]           rounds;
	} fc64_cfg_t;

	function automatic logic [7:0] gf_double(logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
	endfunction

	function automatic logic [15:0] f_word(logic [15:0] w);
		logic [7:0] h;
		logic [7:0] l;
		h = gf_double(w[15:8] ^ w[7:0]);
		l = gf_double(w[7:0] ^ h);
		return {h, l};
	endfunction

	// Key word index (v mod n) for n of 8, 12 or 16; v stays below 36.
	function automatic logic [3:0] key_index(logic [RND_W-1:0] v, logic [1:0] sel);
		logic [3:0] idx;
		unique case (sel)
			KEY_SIZE_16: idx = {1'b0, v[2:0]};
			KEY_SIZE_24: begin
				if (v >= RND_W'(24)) begin
					idx = 4'(v - RND_W'(24));
				end else if (v >= RND_W'(12)) begin
					idx = 4'(v - RND_W'(12));
				end else begin
					idx = v[3:0];
				end
			end
			default: idx = v[3:0];
		endcase
		return idx;
	endfunction

endpackage

### rtl/fc64_cell.sv
// ----------------------------------------------------------------------------
// fc64_cell
// One round stage: applies its round to the passing word, or lets it through.
// ----------------------------------------------------------------------------
module fc64_cell #(
	parameter int INDEX = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  fc64_pkg::fc64_cfg_t    cfg,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  fc64_pkg::fc64_word_t   in_word,
	output logic                   out_valid,
	input  logic                   out_ready,
	output fc64_pkg::fc64_word_t   out_word
);
	import fc64_pkg::*;

	localparam logic [RND_W-1:0] IDX = RND_W'(INDEX);

	logic             valid_q;
	fc64_word_t       word_q;
	fc64_word_t       word_d;
	logic             active;
	logic [RND_W-1:0] rnd;
	logic [15:0]      x   [4];
	logic [15:0]      k   [4];
	logic [15:0]      y   [4];
	logic [15:0]      z   [4];

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_word  = word_q;

	always_comb begin
		active = IDX < cfg.rounds;
		// Decryption walks the rounds backward, so this cell undoes the mirrored one.
		rnd = (in_word.func == FUNC_DEC) ? RND_W'(cfg.rounds - IDX - RND_W'(1)) : IDX;
		for (int j = 0; j < 4; j++) begin
			x[j] = in_word.block[48-16*j +: 16];
			k[j] = cfg.key_words[key_index(RND_W'(rnd + RND_W'(j)), cfg.size_sel)];
		end
		for (int j = 0; j < 4; j++) begin
			y[j] = x[j] ^ k[j];
		end
		if (in_word.func == FUNC_ENC) begin
			z[0] = f_word(y[0]) ^ y[2];
			z[1] = f_word(y[1]) ^ y[3];
			z[2] = y[0];
			z[3] = y[1];
			word_d.block = (IDX + RND_W'(1) < cfg.rounds) ? {z[1], z[2], z[3], z[0]}
			                                              : {z[0], z[1], z[2], z[3]};
		end else begin
			// Undo the rotation first (all but the last round rotate), then the round.
			if (IDX != '0) begin
				z[0] = x[3];
				z[1] = x[0];
				z[2] = x[1];
				z[3] = x[2];
			end else begin
				z[0] = x[0];
				z[1] = x[1];
				z[2] = x[2];
				z[3] = x[3];
			end
			word_d.block = {z[2] ^ k[0], z[3] ^ k[1],
			                z[0] ^ f_word(z[2]) ^ k[2], z[1] ^ f_word(z[3]) ^ k[3]};
		end
		word_d.func = in_word.func;
		if (!active) begin
			word_d.block = in_word.block;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_q <= word_d;
		end
	end

endmodule

### rtl/feistel_block_cipher_64.sv
// ----------------------------------------------------------------------------
// feistel_block_cipher_64
// Pipelined 64-bit Feistel block cipher, one round per stage.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready carry one word (func, block_in); func
// selects encryption or decryption. Output channel: out_valid/out_ready carry
// block_out. Key, key size and round count are written through the cfg port
// (cfg_wr_en, cfg_index, cfg_data); the user must write them only while the
// pipeline is empty, which the block itself does not enforce. The block is a
// row of MAX_ROUNDS round stages, each holding one word; stages past the active
// round count pass the word unchanged. Every word passes all MAX_ROUNDS stages,
// and throughput is one word per cycle while the receiver does not stall.
// Each stage takes a new word when it is empty or its successor moves, so
// when the receiver stalls, empty stages still fill up and in_ready drops only
// once every stage holds a word.
// Reset empties all stages and loads the default key (all zero), 16 byte key
// size and six rounds.
// ----------------------------------------------------------------------------
module feistel_block_cipher_64 #(
	parameter int MAX_ROUNDS = fc64_pkg::MAX_ROUNDS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [fc64_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fc64_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            func,
	input  logic [63:0]                     block_in,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [63:0]                     block_out
);
	import fc64_pkg::*;

	logic [3:0][63:0] key_part_q;
	logic [1:0]       key_size_q;
	logic [4:0]       round_count_q;
	fc64_cfg_t        cfg;

	logic       valid_c [MAX_ROUNDS+1];
	logic       ready_c [MAX_ROUNDS+1];
	fc64_word_t word_c  [MAX_ROUNDS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_part_q    <= '0;
			key_size_q    <= KEY_SIZE_16;
			round_count_q <= ROUNDS_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_KEY_PART_0: key_part_q[0] <= cfg_data;
				REG_KEY_PART_1: key_part_q[1] <= cfg_data;
				REG_KEY_PART_2: key_part_q[2] <= cfg_data;
				REG_KEY_PART_3: key_part_q[3] <= cfg_data;
				REG_KEY_SIZE:   key_size_q    <= cfg_data[1:0];
				REG_ROUNDS:     round_count_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int w = 0; w < KEY_WORDS; w++) begin
			cfg.key_words[w] = key_part_q[w/4][48-16*(w%4) +: 16];
		end
		cfg.size_sel = (key_size_q > KEY_SIZE_32) ? KEY_SIZE_32 : key_size_q;
		cfg.rounds   = (RND_W'(round_count_q) > RND_W'(MAX_ROUNDS))
		               ? RND_W'(MAX_ROUNDS) : RND_W'(round_count_q);
	end

	assign valid_c[0]       = in_valid;
	assign in_ready         = ready_c[0];
	assign word_c[0].func   = func;
	assign word_c[0].block  = block_in;

	for (genvar c = 0; c < MAX_ROUNDS; c++) begin : g_cell
		fc64_cell #(
			.INDEX (c)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cfg       (cfg),
			.in_valid  (valid_c[c]),
			.in_ready  (ready_c[c]),
			.in_word   (word_c[c]),
			.out_valid (valid_c[c+1]),
			.out_ready (ready_c[c+1]),
			.out_word  (word_c[c+1])
		);
	end

	assign ready_c[MAX_ROUNDS] = out_ready;
	assign out_valid           = valid_c[MAX_ROUNDS];
	assign block_out           = word_c[MAX_ROUNDS].block;

endmodule

### rtl/fc64_checker.sv
// ----------------------------------------------------------------------------
// fc64_checker
// Port-level checks of the cipher pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`include "feistel_block_cipher_64_macros.svh"

module fc64_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cfg_wr_en,
	input logic [fc64_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [fc64_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            func,
	input logic [63:0]                     block_in,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [63:0]                     block_out
);
	// A stalled result word stays put until taken.
	`FC64_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(block_out))

	// With the last stage free to move, every stage can move, so input is open.
	`FC64_ASSERT_NOW(a_in_open, clk, arst_n, !out_valid || out_ready, in_ready)

	// The pipeline comes out of reset empty.
	`FC64_ASSERT_NOW(a_reset_empty, clk, arst_n, !$past(arst_n), !out_valid)

endmodule

bind feistel_block_cipher_64 fc64_checker u_fc64_checker (.*);

### tb/tb_feistel_block_cipher_64.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for feistel_block_cipher_64
// Drives blocks to encrypt and decrypt under a series of keys, key sizes and
// round counts. Each accepted block is run through a local cipher model, and
// every returned block is checked against the oldest predicted block.
// ----------------------------------------------------------------------------
module tb;
	import fc64_pkg::*;

	localparam int MAX_ROUNDS  = fc64_pkg::MAX_ROUNDS_DEF;
	localparam int HOLD_CYCLES = 80;
	localparam int STALL_LIMIT = 2000;
	localparam int SWEEP_PHASES = 12;
	localparam int PHASE_BLOCKS = 150;

	// Indexes that decode to no register; writes there must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 3'd7;
	// Key size code past the largest size; saturates to a 32 byte key.
	localparam logic [1:0] KEY_SIZE_OVER = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic                  func;
	logic [63:0]           block_in;
	logic                  out_valid;
	logic                  out_ready;
	logic [63:0]           block_out;

	// Shadow copy of the cipher configuration.
	logic [63:0] key_reg [4];
	logic [1:0]  key_size_reg;
	logic [4:0]  rounds_reg;

	logic [63:0] cipher_out_q [$];
	logic [63:0] want_block;
	int          mismatches;
	int          stall_left;
	int          quiet_cycles;
	bit          idle_en;
	bit          hold_req;

	feistel_block_cipher_64 DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.block_in  (block_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.block_out (block_out)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Cipher model
	// ------------------------------------------------------------------
	function automatic logic [7:0] gf_x2(logic [7:0] v);
		logic [7:0] r;
		r = v << 1;
		if (v[7]) r = r ^ 8'h1b;
		return r;
	endfunction

	function automatic logic [15:0] mix_word(logic [15:0] w);
		logic [7:0] hi;
		logic [7:0] lo;
		hi = gf_x2(w[15:8] ^ w[7:0]);
		lo = gf_x2(w[7:0] ^ hi);
		return {hi, lo};
	endfunction

	function automatic logic [15:0] key_word(int k);
		return key_reg[2'(k / 4)][63 - 16 * (k % 4) -: 16];
	endfunction

	function automatic logic [63:0] cipher_block(logic op, logic [63:0] blk);
		logic [15:0] x [4];
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] t;
		int          nk;
		int          nr;
		nk = (key_size_reg > KEY_SIZE_32) ? 16 : 8 + 4 * int'(key_size_reg);
		nr = (rounds_reg > MAX_ROUNDS) ? MAX_ROUNDS : int'(rounds_reg);
		for (int j = 0; j < 4; j++) x[j] = blk[63 - 16 * j -: 16];
		if (op == FUNC_ENC) begin
			for (int r = 0; r < nr; r++) begin
				for (int j = 0; j < 4; j++) x[j] ^= key_word((r + j) % nk);
				a = x[0];
				b = x[1];
				x[0] = mix_word(a) ^ x[2];
				x[1] = mix_word(b) ^ x[3];
				x[2] = a;
				x[3] = b;
				if (r + 1 < nr) begin
					t = x[0];
					x[0] = x[1];
					x[1] = x[2];
					x[2] = x[3];
					x[3] = t;
				end
			end
		end else begin
			for (int r = nr - 1; r >= 0; r--) begin
				if (r + 1 < nr) begin
					t = x[3];
					x[3] = x[2];
					x[2] = x[1];
					x[1] = x[0];
					x[0] = t;
				end
				a = x[2];
				b = x[3];
				x[2] = x[0] ^ mix_word(a);
				x[3] = x[1] ^ mix_word(b);
				x[0] = a;
				x[1] = b;
				for (int j = 0; j < 4; j++) x[j] ^= key_word((r + j) % nk);
			end
		end
		return {x[0], x[1], x[2], x[3]};
	endfunction

	// Random 64-bit value that hits all zeros and all ones now and then.
	function automatic logic [63:0] pick_block();
		case ($urandom_range(0, 7))
			0: return 64'h0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Shared tasks
	// ------------------------------------------------------------------
	task automatic send_block(input logic op, input logic [63:0] blk);
		int gap;
		gap = idle_en ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= op;
		block_in <= blk;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		cipher_out_q = {cipher_out_q, cipher_block(op, blk)};
	endtask

	task automatic send_random_block();
		send_block($urandom_range(0, 1) ? FUNC_DEC : FUNC_ENC, pick_block());
	endtask

	// Stops the input and waits for every predicted word to come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (cipher_out_q.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val,
			input bit last);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		if (last) cfg_wr_en <= 1'b0;
		case (idx)
			REG_KEY_PART_0, REG_KEY_PART_1, REG_KEY_PART_2, REG_KEY_PART_3:
				key_reg[idx[1:0]] = val;
			REG_KEY_SIZE: key_size_reg = val[1:0];
			REG_ROUNDS:   rounds_reg = val[4:0];
			default: ;
		endcase
	endtask

	task automatic load_config(input logic [63:0] k0, input logic [63:0] k1,
			input logic [63:0] k2, input logic [63:0] k3, input logic [1:0] size_sel,
			input logic [4:0] rounds, input bit with_stray);
		drain();
		write_reg(REG_KEY_PART_0, k0, 1'b0);
		write_reg(REG_KEY_PART_1, k1, 1'b0);
		write_reg(REG_KEY_PART_2, k2, 1'b0);
		write_reg(REG_KEY_PART_3, k3, 1'b0);
		// Upper bits of the narrow registers carry noise that must be dropped.
		write_reg(REG_KEY_SIZE, {$urandom, ($urandom_range(0, 1) ? 30'h0 : 30'(-1)), size_sel},
			1'b0);
		write_reg(REG_ROUNDS, {$urandom, 27'($urandom), rounds}, !with_stray);
		if (with_stray)
			write_reg($urandom_range(0, 1) ? REG_NONE_HI : REG_NONE_LO, {$urandom, $urandom},
				1'b1);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_reset_defaults();
		send_block(FUNC_ENC, 64'h0);
		send_block(FUNC_ENC, '1);
		send_block(FUNC_DEC, 64'h0);
		send_block(FUNC_DEC, '1);
	endtask

	task automatic test_directed_corners();
		load_config('1, '1, '1, '1, KEY_SIZE_32, 5'(MAX_ROUNDS), 1'b0);
		send_block(FUNC_ENC, 64'h0);
		send_block(FUNC_DEC, '1);
		send_block(FUNC_ENC, 64'haaaa_5555_aaaa_5555);
		send_block(FUNC_DEC, 64'h5555_aaaa_5555_aaaa);

		load_config(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 64'h0, 64'h0,
			KEY_SIZE_16, 5'd1, 1'b0);
		send_block(FUNC_ENC, 64'h8080_8080_8080_8080);
		send_block(FUNC_DEC, 64'h8080_8080_8080_8080);

		// No rounds at all: the block passes through untouched.
		load_config('1, '1, 64'h0, '1, KEY_SIZE_24, 5'd0, 1'b0);
		send_block(FUNC_ENC, 64'hdead_beef_0bad_f00d);
		send_block(FUNC_DEC, '1);

		// Oversized key code and a round count far past the pipeline depth.
		load_config(64'h1111_2222_3333_4444, 64'h5555_6666_7777_8888,
			64'h9999_aaaa_bbbb_cccc, 64'hdddd_eeee_ffff_0000, KEY_SIZE_OVER, 5'd31, 1'b0);
		send_block(FUNC_ENC, 64'h0123_4567_89ab_cdef);
		send_block(FUNC_DEC, 64'h0123_4567_89ab_cdef);

		load_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, KEY_SIZE_24, 5'(MAX_ROUNDS + 1), 1'b0);
		send_block(FUNC_ENC, '1);
		send_block(FUNC_DEC, 64'h0);

		// Writes to unmapped indexes must leave the configuration alone.
		drain();
		write_reg(REG_NONE_LO, 64'h0, 1'b0);
		write_reg(REG_NONE_HI, '1, 1'b1);
		send_block(FUNC_ENC, 64'h7fff_ffff_ffff_fffe);
		send_block(FUNC_DEC, 64'h7fff_ffff_ffff_fffe);
	endtask

	task automatic test_output_backpressure();
		load_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, KEY_SIZE_32, 5'd9, 1'b0);
		idle_en  = 1'b0;
		hold_req = 1'b1;
		repeat (60) send_random_block();
		idle_en = 1'b1;
	endtask

	task automatic test_random_sweep();
		logic [4:0] rounds;
		for (int p = 0; p < SWEEP_PHASES; p++) begin
			case ($urandom_range(0, 5))
				0: rounds = 5'd0;
				1: rounds = 5'd1;
				2: rounds = 5'(MAX_ROUNDS);
				3: rounds = 5'($urandom_range(MAX_ROUNDS + 1, 31));
				default: rounds = 5'($urandom_range(0, 31));
			endcase
			load_config(pick_block(), pick_block(), pick_block(), pick_block(),
				2'($urandom_range(0, 3)), rounds, $urandom_range(0, 2) == 0);
			// Every fourth phase runs both sides flat out.
			idle_en = (p % 4 != 3);
			repeat (PHASE_BLOCKS) send_random_block();
		end
		idle_en = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Receiver, checker and watchdog
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) stall_left = idle_en ? $urandom_range(0, 4) : 0;
			if (hold_req) begin
				stall_left = HOLD_CYCLES;
				hold_req   = 1'b0;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (cipher_out_q.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h", $time, block_out);
				mismatches++;
			end else begin
				want_block = cipher_out_q.pop_front();
				if (block_out !== want_block) begin
					$display("%0t: block_out expected %h actual %h", $time, want_block,
						block_out);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n       <= 1'b0;
		cfg_wr_en    <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		func         <= FUNC_ENC;
		block_in     <= '0;
		out_ready    <= 1'b0;
		for (int i = 0; i < 4; i++) key_reg[i] = '0;
		key_size_reg = KEY_SIZE_16;
		rounds_reg   = ROUNDS_RESET;
		mismatches   = 0;
		stall_left   = 0;
		quiet_cycles = 0;
		idle_en      = 1'b1;
		hold_req     = 1'b0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_directed_corners();
		test_output_backpressure();
		test_random_sweep();

		drain();
		repeat (MAX_ROUNDS + 4) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
